// File: design/thumb_instruction_encoder_unit_assert.svh
// Assertion macros shared by the Thumb encoder RTL.
// Depends on a clock named clk and an active-high reset named rst in the using module.
`ifndef THUMB_INSTRUCTION_ENCODER_UNIT_ASSERT_SVH
`define THUMB_INSTRUCTION_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TIE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tie assertion failed");

// Next-cycle implication, checked outside reset.
`define TIE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tie assertion failed");

`endif

// File: design/tie_pkg.sv
// Package for the Thumb instruction encoder: item types, status codes,
// encoding forms and the per-id template and form tables. No dependencies.
`timescale 1ns / 1ps

package tie_pkg;

  localparam int ID_COUNT = 68;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_RANGE   = 2'd1,
    STATUS_ALIGN   = 2'd2,
    STATUS_INVALID = 2'd3
  } tie_status_t;

  typedef enum logic [4:0] {
    FORM_ZERO,
    FORM_RDRM,
    FORM_IMM8,
    FORM_RRR,
    FORM_RDIMM8,
    FORM_IMM3,
    FORM_IMM5,
    FORM_RLIST,
    FORM_LDSTM,
    FORM_IMM5S4,
    FORM_IMM5S2,
    FORM_IMM8S4,
    FORM_HIREG,
    FORM_SP7,
    FORM_B1,
    FORM_B2,
    FORM_BL,
    FORM_BLX,
    FORM_BAD,
    FORM_RMHI
  } tie_form_t;

  typedef struct packed {
    logic [6:0]  cmd;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic [2:0]  reg_c;
    logic [31:0] imm_or_target;
    logic [15:0] reg_mask;
    logic [3:0]  cond_code;
    logic [31:0] pc_value;
  } tie_in_t;

  typedef struct packed {
    logic [31:0] code;
    logic        is_pair;
    logic [1:0]  status;
  } tie_out_t;

  // Halfword templates of the long branch pair: the high-offset prefix and the BL and BLX1 suffixes.
  localparam logic [15:0] BL_HI_TMPL  = 16'hF000;
  localparam logic [15:0] BL_LO_TMPL  = 16'hF800;
  localparam logic [15:0] BLX_LO_TMPL = 16'hE800;

  // Branch offset limits, in bytes from PC+4.
  localparam logic signed [31:0] B1_MIN = -32'sd256;
  localparam logic signed [31:0] B1_MAX = 32'sd254;
  localparam logic signed [31:0] B2_MIN = -32'sd2048;
  localparam logic signed [31:0] B2_MAX = 32'sd2046;
  localparam logic signed [31:0] BL_MIN = -32'sd4194304;
  localparam logic signed [31:0] BL_MAX = 32'sd4194302;

  localparam logic [31:0] PC_AHEAD = 32'd4;

  localparam logic [15:0] TMPL_TABLE [ID_COUNT] = '{
    16'h0000, 16'h0000, 16'h0000, 16'h4140, 16'h4180, 16'h4340, 16'h4000, 16'h4100,
    16'h4380, 16'h4040, 16'h4080, 16'h40C0, 16'h4240, 16'h4300, 16'h41C0, 16'h4200,
    16'h42C0, 16'h4280, 16'h1C00, 16'h43C0, 16'hBE00, 16'hDF00, 16'h5800, 16'h5C00,
    16'h5A00, 16'h5600, 16'h5E00, 16'h5000, 16'h5400, 16'h5200, 16'h2000, 16'h2800,
    16'h3000, 16'h3800, 16'h1C00, 16'h1E00, 16'h1000, 16'h0000, 16'h0800, 16'hBC00,
    16'hB400, 16'h1800, 16'h1A00, 16'hC800, 16'hC000, 16'h6800, 16'h6000, 16'h7800,
    16'h7000, 16'h8800, 16'h8000, 16'h9800, 16'h9000, 16'h4800, 16'h4500, 16'h4400,
    16'h4600, 16'hA000, 16'hA800, 16'hB000, 16'hB080, 16'hD000, 16'hE000, 16'hF800,
    16'hE800, 16'h0000, 16'h4780, 16'h4700
  };

  localparam tie_form_t FORM_TABLE [ID_COUNT] = '{
    FORM_ZERO, FORM_ZERO, FORM_ZERO, FORM_RDRM, FORM_RDRM, FORM_RDRM, FORM_RDRM,
    FORM_RDRM, FORM_RDRM, FORM_RDRM, FORM_RDRM, FORM_RDRM, FORM_RDRM, FORM_RDRM,
    FORM_RDRM, FORM_RDRM, FORM_RDRM, FORM_RDRM, FORM_RDRM, FORM_RDRM, FORM_IMM8,
    FORM_IMM8, FORM_RRR, FORM_RRR, FORM_RRR, FORM_RRR, FORM_RRR, FORM_RRR,
    FORM_RRR, FORM_RRR, FORM_RDIMM8, FORM_RDIMM8, FORM_RDIMM8, FORM_RDIMM8,
    FORM_IMM3, FORM_IMM3, FORM_IMM5, FORM_IMM5, FORM_IMM5, FORM_RLIST,
    FORM_RLIST, FORM_RRR, FORM_RRR, FORM_LDSTM, FORM_LDSTM, FORM_IMM5S4,
    FORM_IMM5S4, FORM_IMM5, FORM_IMM5, FORM_IMM5S2, FORM_IMM5S2, FORM_IMM8S4,
    FORM_IMM8S4, FORM_IMM8S4, FORM_HIREG, FORM_HIREG, FORM_HIREG, FORM_IMM8S4,
    FORM_IMM8S4, FORM_SP7, FORM_SP7, FORM_B1, FORM_B2, FORM_BL,
    FORM_BLX, FORM_BAD, FORM_RMHI, FORM_RMHI
  };

endpackage

// File: design/tie_encode.sv
// Combinational Thumb encoder: one decoded instruction in, one encoding out.
// Depends on tie_pkg for item types, tables and status codes.
`timescale 1ns / 1ps

module tie_encode (
  input  tie_pkg::tie_in_t  item,
  output tie_pkg::tie_out_t result
);
  import tie_pkg::*;

  logic              id_ok;
  tie_form_t         form;
  logic [15:0]       tmpl;
  logic [31:0]       base;
  logic [31:0]       target;
  logic [31:0]       off;
  logic signed [31:0] soff;
  logic [10:0]       b2_half;
  logic [2:0]        ra;
  logic [2:0]        rb;
  logic [15:0]       half_code;

  assign id_ok = item.cmd < 7'(ID_COUNT);
  assign form  = id_ok ? FORM_TABLE[item.cmd] : FORM_BAD;
  assign tmpl  = id_ok ? TMPL_TABLE[item.cmd] : 16'h0000;
  assign ra    = item.reg_a[2:0];
  assign rb    = item.reg_b[2:0];

  // BLX1 lands on a word boundary: bit 1 follows PC+4.
  assign base   = item.pc_value + PC_AHEAD;
  assign target = (form == FORM_BLX)
                ? {item.imm_or_target[31:2], base[1], item.imm_or_target[0]}
                : item.imm_or_target;
  assign off    = target - base;
  assign soff   = $signed(off);

  // Halving rounds toward zero: negative odd offsets move up by one.
  assign b2_half = off[11:1] + {10'd0, off[31] & off[0]};

  always_comb begin
    half_code      = 16'h0000;
    result.code    = 32'd0;
    result.is_pair = 1'b0;
    result.status  = STATUS_OK;
    unique case (form)
      FORM_RDRM:   half_code = tmpl | {10'd0, rb, ra};
      FORM_IMM8:   half_code = tmpl | {8'd0, item.imm_or_target[7:0]};
      FORM_RRR:    half_code = tmpl | {7'd0, item.reg_c, rb, ra};
      FORM_RDIMM8: half_code = tmpl | {5'd0, ra, item.imm_or_target[7:0]};
      FORM_IMM3:   half_code = tmpl | {7'd0, item.imm_or_target[2:0], rb, ra};
      FORM_IMM5:   half_code = tmpl | {5'd0, item.imm_or_target[4:0], rb, ra};
      FORM_IMM5S4: half_code = tmpl | {5'd0, item.imm_or_target[6:2], rb, ra};
      FORM_IMM5S2: half_code = tmpl | {5'd0, item.imm_or_target[5:1], rb, ra};
      FORM_RLIST:  half_code = tmpl | {7'd0, item.reg_mask[15], item.reg_mask[7:0]};
      FORM_LDSTM:  half_code = tmpl | {5'd0, ra, item.reg_mask[7:0]};
      FORM_IMM8S4: half_code = tmpl | {5'd0, ra, item.imm_or_target[9:2]};
      FORM_SP7:    half_code = tmpl | {9'd0, item.imm_or_target[8:2]};
      FORM_HIREG:  half_code = tmpl | {8'd0, item.reg_a[3], item.reg_b[3], rb, ra};
      FORM_RMHI:   half_code = tmpl | {9'd0, item.reg_a, 3'd0};
      FORM_B1: begin
        half_code = tmpl | {4'd0, item.cond_code, off[8:1]};
        if (soff < B1_MIN || soff > B1_MAX) begin
          result.status = STATUS_RANGE;
        end else if (off[0]) begin
          result.status = STATUS_ALIGN;
        end
      end
      FORM_B2: begin
        half_code = tmpl | {5'd0, b2_half};
        if (off[0]) begin
          result.status = STATUS_ALIGN;
        end else if (soff < B2_MIN || soff > B2_MAX) begin
          result.status = STATUS_RANGE;
        end
      end
      FORM_BL, FORM_BLX: begin
        if (soff < BL_MIN || soff > BL_MAX) begin
          result.status = STATUS_RANGE;
        end else if (off[0]) begin
          result.status = STATUS_ALIGN;
        end
        result.is_pair = 1'b1;
      end
      FORM_BAD:    result.status = STATUS_INVALID;
      FORM_ZERO:   half_code = 16'h0000;
      default:     half_code = 16'h0000;
    endcase

    if (form == FORM_BL || form == FORM_BLX) begin
      result.code = {BL_HI_TMPL | {5'd0, off[22:12]},
                     ((form == FORM_BL) ? BL_LO_TMPL : BLX_LO_TMPL) | {5'd0, off[11:1]}};
    end else begin
      result.code = {16'd0, half_code};
    end
  end

endmodule

// File: design/thumb_instruction_encoder_unit.sv
// Top level of the Thumb instruction encoder: input register, encoder, result register.
// Depends on tie_pkg, tie_encode and thumb_instruction_encoder_unit_assert.svh.
`timescale 1ns / 1ps
`include "thumb_instruction_encoder_unit_assert.svh"

// Encodes one decoded instruction per clock, while the output is not stalled,
// into its 16-bit Thumb form, or the 32-bit BL/BLX1 pair (first halfword in
// the upper half, is_pair set). Each item is captured in an input register,
// encoded by a single combinational pass (table lookup, field packing and one
// 32-bit offset subtract with its range compares), and lands in a result
// register, where enc_valid rises; throughput one item per cycle while
// enc_stall is low. A stalled result
// holds in the result register while one more item can still be taken into
// the input register; only when both are full does instr_stall rise. Status
// reports offset range or alignment faults for branches (the encoding is still
// produced from the cut offset) and an invalid id for the prefix id and ids
// beyond the table. No configuration and no state beyond the pipeline.
module thumb_instruction_encoder_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              instr_valid,
  output logic              instr_stall,
  input  tie_pkg::tie_in_t  instr,
  output logic              enc_valid,
  input  logic              enc_stall,
  output tie_pkg::tie_out_t enc
);
  import tie_pkg::*;

  tie_in_t  stage;        // captured instruction
  logic     stage_valid;
  tie_out_t result;
  logic     out_free;     // result register can take a new item
  logic     accept;

  assign out_free    = !enc_valid || !enc_stall;
  assign instr_stall = stage_valid && !out_free;
  assign accept      = instr_valid && !instr_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!instr_stall) begin
      stage_valid <= instr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= instr;
    end
  end

  tie_encode u_encode (
    .item   (stage),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      enc_valid <= 1'b0;
    end else if (out_free) begin
      enc_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stage_valid) begin
      enc <= result;
    end
  end

  // An item in the input register moves on when the result side is empty.
  `TIE_ASSERT_NEXT(a_stage_moves, stage_valid && !enc_valid, enc_valid)
  // Input stalls only with both registers holding items.
  `TIE_ASSERT_NOW(a_stall_full, instr_stall, stage_valid && enc_valid)
  // Invalid ids give an empty single encoding.
  `TIE_ASSERT_NOW(a_invalid_empty, enc_valid && enc.status == STATUS_INVALID,
                  enc.code == 32'd0 && !enc.is_pair)
  // A long branch pair always opens with the high-offset prefix.
  `TIE_ASSERT_NOW(a_pair_prefix, enc_valid && enc.is_pair,
                  enc.code[31:27] == BL_HI_TMPL[15:11])

endmodule
